// ===== rtl/erint_pkg.sv =====
// ----------------------------------------------------------------------------
// erint_pkg
// Shared constants for the eased range interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package erint_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int LOG_BITS       = 32;
    localparam int LOG_FRAC       = 31;
    localparam int LOG_CELLS      = 32;

    localparam logic [1:0] MODE_LINEAR   = 2'd0;
    localparam logic [1:0] MODE_LOG_OUT  = 2'd1;
    localparam logic [1:0] MODE_LOG_IN   = 2'd2;
    localparam logic [1:0] MODE_INVALID  = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/erint_div_cell.sv =====
// ----------------------------------------------------------------------------
// erint_div_cell
// One restoring division step: shift (when SHIFT is set), compare, subtract, append quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none
module erint_div_cell
    import erint_pkg::*;
#(
    parameter int RW    = 33,
    parameter int QW    = 17,
    parameter int SW    = 8,
    parameter bit SHIFT = 1'b1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [SW-1:0] in_side,
    input  wire logic [RW-1:0] in_r,
    input  wire logic [RW-2:0] in_d,
    input  wire logic [QW-1:0] in_q,
    output logic               out_valid,
    output logic [SW-1:0]      out_side,
    output logic [RW-1:0]      out_r,
    output logic [RW-2:0]      out_d,
    output logic [QW-1:0]      out_q
);
    logic          valid_reg;
    logic [SW-1:0] side_reg;
    logic [RW-1:0] r_reg;
    logic [RW-2:0] d_reg;
    logic [QW-1:0] q_reg;
    logic [RW-1:0] r_sh;
    logic [RW-1:0] d_ext;
    logic          ge;
    logic [RW-1:0] r_next;
    logic [QW-1:0] q_next;

    always_comb
    begin
        r_sh   = SHIFT ? {in_r[RW-2:0], 1'b0} : in_r;
        d_ext  = {1'b0, in_d};
        ge     = (r_sh >= d_ext);
        r_next = ge ? (r_sh - d_ext) : r_sh;
        q_next = SHIFT ? {in_q[QW-2:0], ge} : {{(QW-1){1'b0}}, ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            r_reg    <= r_next;
            d_reg    <= in_d;
            q_reg    <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_r     = r_reg;
    assign out_d     = d_reg;
    assign out_q     = q_reg;
endmodule
`default_nettype wire

// ===== rtl/erint_log_cell.sv =====
// ----------------------------------------------------------------------------
// erint_log_cell
// One log2 bit by squaring: square, renormalize, shift the result bit in.
// ----------------------------------------------------------------------------
`default_nettype none
module erint_log_cell
    import erint_pkg::*;
#(
    parameter int SW = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [SW-1:0]       in_side,
    input  wire logic [LOG_BITS-1:0] in_x,
    input  wire logic [LOG_BITS-1:0] in_y,
    output logic                     out_valid,
    output logic [SW-1:0]            out_side,
    output logic [LOG_BITS-1:0]      out_x,
    output logic [LOG_BITS-1:0]      out_y
);
    logic                  valid_reg;
    logic [SW-1:0]         side_reg;
    logic [LOG_BITS-1:0]   x_reg;
    logic [LOG_BITS-1:0]   y_reg;
    logic [2*LOG_BITS-1:0] sq;
    logic [LOG_BITS:0]     t;
    logic [LOG_BITS-1:0]   x_next;

    always_comb
    begin
        sq     = in_x * in_x;
        t      = sq[LOG_FRAC+LOG_BITS:LOG_FRAC];
        x_next = t[LOG_BITS] ? t[LOG_BITS:1] : t[LOG_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            x_reg    <= x_next;
            y_reg    <= {in_y[LOG_BITS-2:0], t[LOG_BITS]};
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
endmodule
`default_nettype wire

// ===== rtl/eased_range_interpolator.sv =====
// ----------------------------------------------------------------------------
// eased_range_interpolator
// Clamp, divide, optional log2 easing and scaling onto the output range.
// ----------------------------------------------------------------------------
// Registers in order: front, division cells, log2 cells, weight, product, output.
// Throughput: one item per cycle; the division and log2 cell rows hold one
// item per cell and all advance together.
// The whole row stalls only when the output register is full and not taken.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module eased_range_interpolator
    import erint_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_W  = ((5*DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((DATA_WIDTH + FRAC_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // position, range_start, range_end, out_start, out_end
    input  wire logic [IN_W-1:0]  s_tdata,
    // func
    input  wire logic [1:0]       s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // value, weight
    output logic [OUT_W-1:0]      m_tdata,
    // range_bad, mode_bad
    output logic [1:0]            m_tuser
);
    localparam int DW  = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int RW  = DW + 1;
    localparam int QW  = F + 1;
    localparam int SW  = 2 + 1 + 1 + DW + 1 + RW;
    localparam int LSW = SW + QW;
    localparam int ND  = F + 1;

    logic adv;

    logic signed [DW-1:0] pos, rs, re, os, oe;
    logic                 rbad, mbad;
    logic signed [DW-1:0] cur;
    logic signed [DW:0]   n_w, d_w, diff;
    logic                 neg;
    logic [RW-1:0]        mag;

    logic                 f_valid_reg;
    logic [SW-1:0]        f_side_reg;
    logic [RW-1:0]        f_n_reg;
    logic [DW-1:0]        f_d_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        pos  = s_tdata[0*DW +: DW];
        rs   = s_tdata[1*DW +: DW];
        re   = s_tdata[2*DW +: DW];
        os   = s_tdata[3*DW +: DW];
        oe   = s_tdata[4*DW +: DW];
        rbad = !(re > rs);
        mbad = (s_tuser == MODE_INVALID);
        cur  = (pos < rs) ? rs : ((pos > re) ? re : pos);
        n_w  = {cur[DW-1], cur} - {rs[DW-1], rs};
        d_w  = {re[DW-1], re} - {rs[DW-1], rs};
        diff = {oe[DW-1], oe} - {os[DW-1], os};
        neg  = diff[DW];
        mag  = neg ? (RW'(0) - RW'(diff)) : RW'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_side_reg <= {mag, neg, os, mbad, rbad, s_tuser};
            f_n_reg    <= (rbad || mbad) ? RW'(0) : {1'b0, n_w[DW-1:0]};
            f_d_reg    <= (rbad || mbad) ? DW'(1) : d_w[DW-1:0];
        end
    end

    logic          dv [ND+1];
    logic [SW-1:0] ds [ND+1];
    logic [RW-1:0] dr [ND+1];
    logic [DW-1:0] dd [ND+1];
    logic [QW-1:0] dq [ND+1];

    assign dv[0] = f_valid_reg;
    assign ds[0] = f_side_reg;
    assign dr[0] = f_n_reg;
    assign dd[0] = f_d_reg;
    assign dq[0] = '0;

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        erint_div_cell #(
            .RW(RW), .QW(QW), .SW(SW), .SHIFT(i != 0)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .in_valid(dv[i]), .in_side(ds[i]), .in_r(dr[i]), .in_d(dd[i]), .in_q(dq[i]),
            .out_valid(dv[i+1]), .out_side(ds[i+1]), .out_r(dr[i+1]),
            .out_d(dd[i+1]), .out_q(dq[i+1])
        );
    end

    logic                lv [LOG_CELLS+1];
    logic [LSW-1:0]      ls [LOG_CELLS+1];
    logic [LOG_BITS-1:0] lx [LOG_CELLS+1];
    logic [LOG_BITS-1:0] ly [LOG_CELLS+1];
    logic [QW:0]         x_sum;

    assign x_sum = {1'b0, dq[ND]} + (QW+1)'(1 << F);
    assign lv[0] = dv[ND];
    assign ls[0] = {dq[ND], ds[ND]};
    assign lx[0] = LOG_BITS'({x_sum, {(LOG_FRAC-F){1'b0}}});
    assign ly[0] = '0;

    for (genvar k = 0; k < LOG_CELLS; k++)
    begin : g_log
        erint_log_cell #(.SW(LSW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .in_valid(lv[k]), .in_side(ls[k]), .in_x(lx[k]), .in_y(ly[k]),
            .out_valid(lv[k+1]), .out_side(ls[k+1]), .out_x(lx[k+1]), .out_y(ly[k+1])
        );
    end

    logic [1:0]     e_func;
    logic           e_rbad, e_mbad, e_neg;
    logic [DW-1:0]  e_os;
    logic [RW-1:0]  e_mag;
    logic [QW-1:0]  e_p;
    logic [LOG_BITS:0] y_rnd;
    logic [QW-1:0]  w_calc;

    always_comb
    begin
        {e_p, e_mag, e_neg, e_os, e_mbad, e_rbad, e_func} = ls[LOG_CELLS];
        y_rnd = {1'b0, ly[LOG_CELLS]} + ((LOG_BITS+1)'(1) << (LOG_FRAC - F));
        if (e_rbad || e_mbad)
            w_calc = '0;
        else if (e_func == MODE_LINEAR || e_p[F])
            w_calc = e_p;
        else
            w_calc = QW'(y_rnd >> (LOG_BITS - F));
    end

    logic          w_valid_reg;
    logic [QW-1:0] w_reg;
    logic [RW-1:0] w_mag_reg;
    logic          w_neg_reg, w_rbad_reg, w_mbad_reg;
    logic [DW-1:0] w_os_reg;

    logic          p_valid_reg;
    logic [RW+QW-1:0] p_prod_reg;
    logic [QW-1:0] p_w_reg;
    logic          p_neg_reg, p_rbad_reg, p_mbad_reg;
    logic [DW-1:0] p_os_reg;

    logic             o_valid_reg;
    logic [DW-1:0]    o_value_reg;
    logic [QW-1:0]    o_w_reg;
    logic             o_rbad_reg, o_mbad_reg;
    logic [RW+QW-1:0] prod_rnd;
    logic [DW-1:0]    scaled;

    always_comb
    begin
        prod_rnd = p_prod_reg + (RW+QW)'(1 << (F-1));
        scaled   = DW'(prod_rnd >> F);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            w_valid_reg <= lv[LOG_CELLS];
            p_valid_reg <= w_valid_reg;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg      <= w_calc;
            w_mag_reg  <= e_mag;
            w_neg_reg  <= e_neg;
            w_rbad_reg <= e_rbad;
            w_mbad_reg <= e_mbad;
            w_os_reg   <= e_os;

            p_prod_reg <= (RW+QW)'(w_mag_reg) * (RW+QW)'(w_reg);
            p_w_reg    <= w_reg;
            p_neg_reg  <= w_neg_reg;
            p_rbad_reg <= w_rbad_reg;
            p_mbad_reg <= w_mbad_reg;
            p_os_reg   <= w_os_reg;

            o_value_reg <= p_neg_reg ? (p_os_reg - scaled) : (p_os_reg + scaled);
            o_w_reg     <= p_w_reg;
            o_rbad_reg  <= p_rbad_reg;
            o_mbad_reg  <= p_mbad_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = OUT_W'({o_w_reg, o_value_reg});
    assign m_tuser  = {o_mbad_reg, o_rbad_reg};
endmodule
`default_nettype wire

// ===== rtl/erint_checker.sv =====
// ----------------------------------------------------------------------------
// erint_checker
// Port-level checks for the eased range interpolator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
module erint_checker
    import erint_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int OUT_W = ((DATA_WIDTH + FRAC_BITS + 1 + 7) / 8) * 8
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic [1:0]       m_tuser
);
    logic [FRAC_BITS:0] w;
    assign w = m_tdata[DATA_WIDTH +: FRAC_BITS+1];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    a_mode_w: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> w == '0)
        else $error("weight nonzero on invalid mode");

    a_range_w: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> w == '0)
        else $error("weight nonzero on bad range");

    a_w_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> w <= (FRAC_BITS+1)'(1 << FRAC_BITS))
        else $error("weight above one");
endmodule

bind eased_range_interpolator erint_checker #(
    .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_erint_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
